### design/vmx_pkg.sv
// Shared widths, codes and limits for the voice mixer.
package vmx_pkg;

  localparam int PORT_VOICES = 4;
  localparam int PCM_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int RATE_W      = 19;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 19;
  localparam int SCALED_W    = 17;
  localparam int MIX_W       = 20;
  localparam int TOTAL_W     = 32;
  localparam int COUNT_W     = 3;
  localparam int GAIN_SHIFT  = 15;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

  localparam logic signed [MIX_W-1:0] PCM_CLIP_HI = 20'sd32767;
  localparam logic signed [MIX_W-1:0] PCM_CLIP_LO = -20'sd32768;

  typedef enum logic [0:0] {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MUSIC_GAIN = 2'd0,
    CFG_SOUND_GAIN = 2'd1,
    CFG_RATE       = 2'd2
  } cfg_reg_t;

endpackage

### design/voice_mixer_with_slot_stealing.sv
// Top level of the four-slot voice mixer with oldest-voice stealing.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall   kind .. voice_end_mask
//   out       source     out_valid / out_stall mixed_sample .. replaced_total
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle is sustained while the output is not stalled; the result
// passes through the input register, then the result register.
// The gain multipliers and the slot selection sit between those registers.
// Reset clears slots, serials, counters and both valid flags; gains return to unity.
// A stalled output holds its result; the input register keeps taking a
// transaction as long as it can move into the result register.
module voice_mixer_with_slot_stealing #(
  parameter int VOICES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic                                open_ok,
  input  logic                                stream_ok,
  input  logic                                music_present,
  input  logic signed [vmx_pkg::PCM_W-1:0]    music_sample,
  input  logic signed [vmx_pkg::PCM_W-1:0]    voice_sample_0,
  input  logic signed [vmx_pkg::PCM_W-1:0]    voice_sample_1,
  input  logic signed [vmx_pkg::PCM_W-1:0]    voice_sample_2,
  input  logic signed [vmx_pkg::PCM_W-1:0]    voice_sample_3,
  input  logic [vmx_pkg::PORT_VOICES-1:0]     voice_end_mask,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vmx_pkg::PCM_W-1:0]    mixed_sample,
  output logic                                accepted,
  output logic [1:0]                          slot,
  output logic                                replaced,
  output logic [vmx_pkg::PORT_VOICES-1:0]     active_mask,
  output logic [vmx_pkg::COUNT_W-1:0]         active_count,
  output logic [vmx_pkg::COUNT_W-1:0]         voice_peak,
  output logic [vmx_pkg::TOTAL_W-1:0]         rejected_total,
  output logic [vmx_pkg::TOTAL_W-1:0]         replaced_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vmx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vmx_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vmx_pkg::*;

  localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [GAIN_W-1:0] music_gain;
  logic [GAIN_W-1:0] sound_gain;
  logic [RATE_W-1:0] rate_setting;

  logic                    s1_valid;
  logic                    s1_kind;
  logic                    s1_open_ok;
  logic                    s1_stream_ok;
  logic                    s1_music_present;
  logic signed [PCM_W-1:0] s1_music;
  logic signed [PCM_W-1:0] s1_voice [VOICES];
  logic [VOICES-1:0]       s1_ends;

  logic signed [PCM_W-1:0] voice_in [PORT_VOICES];

  logic [VOICES-1:0]        slot_active;
  logic [TOTAL_W-1:0]       slot_serial [VOICES];
  logic [TOTAL_W-1:0]       start_counter;
  logic [COUNT_W-1:0]       peak_count;
  logic [TOTAL_W-1:0]       rejected_count;
  logic [TOTAL_W-1:0]       replaced_count;

  logic [VOICES-1:0]        slot_active_next;
  logic [TOTAL_W-1:0]       slot_serial_next [VOICES];
  logic [TOTAL_W-1:0]       start_counter_next;
  logic [COUNT_W-1:0]       peak_count_next;
  logic [TOTAL_W-1:0]       rejected_count_next;
  logic [TOTAL_W-1:0]       replaced_count_next;

  logic signed [PCM_W-1:0]  mixed_next;
  logic                     accepted_next;
  logic [1:0]               slot_next;
  logic                     replaced_next;
  logic [PORT_VOICES-1:0]   mask_next;
  logic [COUNT_W-1:0]       count_next;

  logic signed [SCALED_W-1:0] music_scaled;
  logic signed [SCALED_W-1:0] voice_scaled [VOICES];

  logic out_load;
  logic s1_adv;
  logic in_take;

  assign voice_in[0] = voice_sample_0;
  assign voice_in[1] = voice_sample_1;
  assign voice_in[2] = voice_sample_2;
  assign voice_in[3] = voice_sample_3;

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_load;
  assign in_stall  = s1_valid && !out_load;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      music_gain   <= GAIN_RESET;
      sound_gain   <= GAIN_RESET;
      rate_setting <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MUSIC_GAIN: music_gain   <= cfg_data[GAIN_W-1:0];
        CFG_SOUND_GAIN: sound_gain   <= cfg_data[GAIN_W-1:0];
        CFG_RATE:       rate_setting <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind          <= kind;
      s1_open_ok       <= open_ok;
      s1_stream_ok     <= stream_ok;
      s1_music_present <= music_present;
      s1_music         <= music_sample;
      s1_ends          <= voice_end_mask[VOICES-1:0];
      for (int i = 0; i < VOICES; i++) begin
        s1_voice[i] <= voice_in[i];
      end
    end
  end

  vmx_scale u_music_scale (
    .sample (s1_music),
    .gain   (music_gain),
    .scaled (music_scaled)
  );

  for (genvar g = 0; g < VOICES; g++) begin : g_voice
    vmx_scale u_voice_scale (
      .sample (s1_voice[g]),
      .gain   (sound_gain),
      .scaled (voice_scaled[g])
    );
  end

  always_comb begin
    logic signed [MIX_W-1:0] mix_sum;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_sel;
    logic [SLOT_W-1:0]       steal_sel;
    logic [SLOT_W-1:0]       sel;
    logic [TOTAL_W-1:0]      min_serial;
    logic [TOTAL_W-1:0]      serial_inc;
    logic [TOTAL_W-1:0]      serial_new;

    mix_sum = s1_music_present ? MIX_W'(music_scaled) : '0;
    for (int i = 0; i < VOICES; i++) begin
      if (slot_active[i]) begin
        mix_sum = mix_sum + MIX_W'(voice_scaled[i]);
      end
    end

    free_found = 1'b0;
    free_sel   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_sel   = SLOT_W'(i);
      end
    end

    steal_sel  = '0;
    min_serial = slot_serial[0];
    for (int i = 1; i < VOICES; i++) begin
      if (slot_serial[i] < min_serial) begin
        min_serial = slot_serial[i];
        steal_sel  = SLOT_W'(i);
      end
    end
    sel = free_found ? free_sel : steal_sel;

    serial_inc = start_counter + TOTAL_W'(1);
    serial_new = (serial_inc == '0) ? TOTAL_W'(1) : serial_inc;

    slot_active_next    = slot_active;
    slot_serial_next    = slot_serial;
    start_counter_next  = start_counter;
    peak_count_next     = peak_count;
    rejected_count_next = rejected_count;
    replaced_count_next = replaced_count;
    mixed_next          = '0;
    accepted_next       = 1'b0;
    slot_next           = '0;
    replaced_next       = 1'b0;

    case (kind_t'(s1_kind))
      KIND_SAMPLE: begin
        if (mix_sum > PCM_CLIP_HI) begin
          mixed_next = PCM_CLIP_HI[PCM_W-1:0];
        end else if (mix_sum < PCM_CLIP_LO) begin
          mixed_next = PCM_CLIP_LO[PCM_W-1:0];
        end else begin
          mixed_next = mix_sum[PCM_W-1:0];
        end
        slot_active_next = slot_active & ~s1_ends;
      end
      KIND_START: begin
        if (rate_setting == '0 || !s1_open_ok) begin
          rejected_count_next = rejected_count + TOTAL_W'(1);
        end else begin
          slot_next     = 2'(sel);
          replaced_next = !free_found;
          if (!free_found) begin
            replaced_count_next = replaced_count + TOTAL_W'(1);
          end
          if (!s1_stream_ok) begin
            rejected_count_next = rejected_count + TOTAL_W'(1);
          end else begin
            start_counter_next     = serial_new;
            slot_serial_next[sel]  = serial_new;
            slot_active_next[sel]  = 1'b1;
            accepted_next          = 1'b1;
          end
        end
      end
      default: ;
    endcase

    mask_next               = '0;
    mask_next[VOICES-1:0]   = slot_active_next;
    count_next              = '0;
    for (int i = 0; i < VOICES; i++) begin
      count_next = count_next + COUNT_W'(slot_active_next[i]);
    end
    if (accepted_next && count_next > peak_count) begin
      peak_count_next = count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active    <= '0;
      start_counter  <= '0;
      peak_count     <= '0;
      rejected_count <= '0;
      replaced_count <= '0;
      for (int i = 0; i < VOICES; i++) begin
        slot_serial[i] <= '0;
      end
    end else if (s1_adv) begin
      slot_active    <= slot_active_next;
      start_counter  <= start_counter_next;
      peak_count     <= peak_count_next;
      rejected_count <= rejected_count_next;
      replaced_count <= replaced_count_next;
      slot_serial    <= slot_serial_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mixed_sample   <= mixed_next;
      accepted       <= accepted_next;
      slot           <= slot_next;
      replaced       <= replaced_next;
      active_mask    <= mask_next;
      active_count   <= count_next;
      voice_peak     <= peak_count_next;
      rejected_total <= rejected_count_next;
      replaced_total <= replaced_count_next;
    end
  end

endmodule

### design/vmx_scale.sv
// Q15 gain multiply with truncation toward zero.
module vmx_scale (
  input  logic signed [vmx_pkg::PCM_W-1:0]    sample,
  input  logic        [vmx_pkg::GAIN_W-1:0]   gain,
  output logic signed [vmx_pkg::SCALED_W-1:0] scaled
);
  import vmx_pkg::*;

  localparam int PROD_W = PCM_W + GAIN_W + 1;

  logic signed [PROD_W-1:0]            product;
  logic signed [PROD_W-1:0]            biased;
  logic signed [PROD_W-GAIN_SHIFT-1:0] shifted;

  assign product = PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));
  assign biased  = product[PROD_W-1] ?
                   product + PROD_W'((1 << GAIN_SHIFT) - 1) : product;
  assign shifted = biased[PROD_W-1:GAIN_SHIFT];
  assign scaled  = shifted[SCALED_W-1:0];

endmodule

### design/vmx_checker.sv
// Port-level checks for the voice mixer, bound to the top level.
module vmx_checker #(
  parameter int VOICES = 4
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic signed [vmx_pkg::PCM_W-1:0]   mixed_sample,
  input logic                               accepted,
  input logic                               replaced,
  input logic [vmx_pkg::PORT_VOICES-1:0]    active_mask,
  input logic [vmx_pkg::COUNT_W-1:0]        active_count
);
  import vmx_pkg::*;

  localparam logic [PORT_VOICES-1:0] FULL_MASK = PORT_VOICES'((1 << VOICES) - 1);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> active_count == COUNT_W'($countones(active_mask)))
    else $error("active count disagrees with active mask");

  a_steal_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced |-> (active_mask & FULL_MASK) == FULL_MASK)
    else $error("steal reported while a slot was free");

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> mixed_sample == '0 && active_count != '0)
    else $error("accepted start with nonzero mix or no active slot");

endmodule

bind voice_mixer_with_slot_stealing vmx_checker #(.VOICES(VOICES)) u_vmx_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .mixed_sample (mixed_sample),
  .accepted     (accepted),
  .replaced     (replaced),
  .active_mask  (active_mask),
  .active_count (active_count)
);

### tb/vmx_mix_checker.sv
// Checker for the voice mixer: predicts each result and compares it with the block's output.
module vmx_mix_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 kind,
  input  logic                                 open_ok,
  input  logic                                 stream_ok,
  input  logic                                 music_present,
  input  logic signed [vmx_pkg::PCM_W-1:0]     music_sample,
  input  logic signed [vmx_pkg::PCM_W-1:0]     voice_sample_0,
  input  logic signed [vmx_pkg::PCM_W-1:0]     voice_sample_1,
  input  logic signed [vmx_pkg::PCM_W-1:0]     voice_sample_2,
  input  logic signed [vmx_pkg::PCM_W-1:0]     voice_sample_3,
  input  logic [vmx_pkg::PORT_VOICES-1:0]      voice_end_mask,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [vmx_pkg::PCM_W-1:0]     mixed_sample,
  input  logic                                 accepted,
  input  logic [1:0]                           slot,
  input  logic                                 replaced,
  input  logic [vmx_pkg::PORT_VOICES-1:0]      active_mask,
  input  logic [vmx_pkg::COUNT_W-1:0]          active_count,
  input  logic [vmx_pkg::COUNT_W-1:0]          voice_peak,
  input  logic [vmx_pkg::TOTAL_W-1:0]          rejected_total,
  input  logic [vmx_pkg::TOTAL_W-1:0]          replaced_total,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [vmx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vmx_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                   mismatches,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import vmx_pkg::*;

  localparam longint UNITY_GAIN = 64'sd32768;

  typedef struct packed {
    logic signed [PCM_W-1:0] mixed_sample;
    logic                    accepted;
    logic [1:0]              slot;
    logic                    replaced;
    logic [PORT_VOICES-1:0]  active_mask;
    logic [COUNT_W-1:0]      active_count;
    logic [COUNT_W-1:0]      voice_peak;
    logic [TOTAL_W-1:0]      rejected_total;
    logic [TOTAL_W-1:0]      replaced_total;
  } mix_result_t;

  logic [GAIN_W-1:0]      gain_music;
  logic [GAIN_W-1:0]      gain_sound;
  logic [RATE_W-1:0]      rate;
  logic [PORT_VOICES-1:0] voice_on;
  logic [TOTAL_W-1:0]     voice_serial [PORT_VOICES];
  logic [TOTAL_W-1:0]     serial_ctr;
  logic [COUNT_W-1:0]     peak;
  logic [TOTAL_W-1:0]     reject_cnt;
  logic [TOTAL_W-1:0]     steal_cnt;
  mix_result_t            pending_mixes [$];
  mix_result_t            want;
  int                     fail_count = 0;

  assign mismatches = fail_count;

  function automatic int q15_scale(logic signed [PCM_W-1:0] pcm, logic [GAIN_W-1:0] gain);
    longint prod;
    prod = longint'(pcm) * longint'(gain);
    return int'(prod / UNITY_GAIN);
  endfunction

  function automatic mix_result_t mix_predict(kind_t op, logic hdr_ok, logic setup_ok,
                                              logic music_on, logic signed [PCM_W-1:0] music,
                                              logic [PORT_VOICES-1:0][PCM_W-1:0] pcm,
                                              logic [PORT_VOICES-1:0] ends);
    mix_result_t r;
    int          acc;
    int          pick;
    r = '0;
    if (op == KIND_SAMPLE) begin
      acc = music_on ? q15_scale(music, gain_music) : 0;
      for (int i = 0; i < PORT_VOICES; i++) begin
        if (voice_on[i]) begin
          acc += q15_scale($signed(pcm[i]), gain_sound);
          if (ends[i]) voice_on[i] = 1'b0;
        end
      end
      if (acc > PCM_CLIP_HI) acc = PCM_CLIP_HI;
      if (acc < PCM_CLIP_LO) acc = PCM_CLIP_LO;
      r.mixed_sample = 16'(acc);
    end else if (rate == '0 || !hdr_ok) begin
      reject_cnt++;
    end else begin
      pick = -1;
      for (int i = 0; i < PORT_VOICES; i++) begin
        if (!voice_on[i] && pick < 0) pick = i;
      end
      if (pick < 0) begin
        pick = 0;
        for (int i = 1; i < PORT_VOICES; i++) begin
          if (voice_serial[i] < voice_serial[pick]) pick = i;
        end
        r.replaced = 1'b1;
        steal_cnt++;
      end
      r.slot = 2'(pick);
      if (!setup_ok) begin
        reject_cnt++;
      end else begin
        serial_ctr++;
        if (serial_ctr == '0) serial_ctr = 1;
        voice_serial[pick] = serial_ctr;
        voice_on[pick] = 1'b1;
        r.accepted = 1'b1;
        if ($countones(voice_on) > peak) peak = COUNT_W'($countones(voice_on));
      end
    end
    r.active_mask    = voice_on;
    r.active_count   = COUNT_W'($countones(voice_on));
    r.voice_peak     = peak;
    r.rejected_total = reject_cnt;
    r.replaced_total = steal_cnt;
    return r;
  endfunction

  function automatic void check_field(string field, longint expected, longint actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_music = GAIN_RESET;
      gain_sound = GAIN_RESET;
      rate       = '0;
      voice_on   = '0;
      for (int i = 0; i < PORT_VOICES; i++) voice_serial[i] = '0;
      serial_ctr = '0;
      peak       = '0;
      reject_cnt = '0;
      steal_cnt  = '0;
      pending_mixes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MUSIC_GAIN: gain_music = cfg_data[GAIN_W-1:0];
          CFG_SOUND_GAIN: gain_sound = cfg_data[GAIN_W-1:0];
          CFG_RATE:       rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_mixes.push_back(mix_predict(kind_t'(kind), open_ok, stream_ok, music_present,
                                            music_sample,
                                            {voice_sample_3, voice_sample_2,
                                             voice_sample_1, voice_sample_0},
                                            voice_end_mask));
      end
      if (out_valid && !out_stall) begin
        if (pending_mixes.size() == 0) begin
          $error("result transaction with no input pending");
          fail_count++;
        end else begin
          want = pending_mixes.pop_front();
          check_field("mixed_sample", want.mixed_sample, mixed_sample);
          check_field("accepted", want.accepted, accepted);
          check_field("slot", want.slot, slot);
          check_field("replaced", want.replaced, replaced);
          check_field("active_mask", want.active_mask, active_mask);
          check_field("active_count", want.active_count, active_count);
          check_field("voice_peak", want.voice_peak, voice_peak);
          check_field("rejected_total", want.rejected_total, rejected_total);
          check_field("replaced_total", want.replaced_total, replaced_total);
        end
      end
    end
    outstanding <= pending_mixes.size();
  end

endmodule

### tb/voice_mixer_with_slot_stealing_tb.sv
// Top of the voice mixer testbench: clock, reset, stimulus, output stalls and verdict.
module voice_mixer_with_slot_stealing_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vmx_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_CYCLES   = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    kind_t                             kind;
    logic                              open_ok;
    logic                              stream_ok;
    logic                              music_present;
    logic [PCM_W-1:0]                  music;
    logic [PORT_VOICES-1:0][PCM_W-1:0] voice;
    logic [PORT_VOICES-1:0]            ends;
  } mix_item_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          kind = 1'b0;
  logic                          open_ok = 1'b0;
  logic                          stream_ok = 1'b0;
  logic                          music_present = 1'b0;
  logic signed [PCM_W-1:0]       music_sample = '0;
  logic signed [PCM_W-1:0]       voice_sample_0 = '0;
  logic signed [PCM_W-1:0]       voice_sample_1 = '0;
  logic signed [PCM_W-1:0]       voice_sample_2 = '0;
  logic signed [PCM_W-1:0]       voice_sample_3 = '0;
  logic [PORT_VOICES-1:0]        voice_end_mask = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [PCM_W-1:0]       mixed_sample;
  logic                          accepted;
  logic [1:0]                    slot;
  logic                          replaced;
  logic [PORT_VOICES-1:0]        active_mask;
  logic [COUNT_W-1:0]            active_count;
  logic [COUNT_W-1:0]            voice_peak;
  logic [TOTAL_W-1:0]            rejected_total;
  logic [TOTAL_W-1:0]            replaced_total;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  int                            mismatches;
  int                            outstanding;

  int cycle_count  = 0;
  int gap_max      = 3;
  int starts_sent  = 0;
  int samples_sent = 0;
  int settings     = 1;

  voice_mixer_with_slot_stealing i_dut (.*);
  vmx_mix_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [PCM_W-1:0] pcm_value();
    logic [PCM_W-1:0] v;
    case ($urandom_range(9, 0))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      default: v = PCM_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic mix_item_t start_item(logic hdr_ok, logic setup_ok);
    mix_item_t it;
    it.kind          = KIND_START;
    it.open_ok       = hdr_ok;
    it.stream_ok     = setup_ok;
    it.music_present = 1'($urandom);
    it.music         = PCM_W'($urandom);
    it.voice         = {$urandom, $urandom};
    it.ends          = PORT_VOICES'($urandom);
    return it;
  endfunction

  function automatic mix_item_t sample_item(logic music_on, logic [PCM_W-1:0] music,
                                            logic [PORT_VOICES-1:0][PCM_W-1:0] pcm,
                                            logic [PORT_VOICES-1:0] ends);
    mix_item_t it;
    it.kind          = KIND_SAMPLE;
    it.open_ok       = 1'($urandom);
    it.stream_ok     = 1'($urandom);
    it.music_present = music_on;
    it.music         = music;
    it.voice         = pcm;
    it.ends          = ends;
    return it;
  endfunction

  task automatic post_item(input mix_item_t it);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= it.kind;
    open_ok        <= it.open_ok;
    stream_ok      <= it.stream_ok;
    music_present  <= it.music_present;
    music_sample   <= it.music;
    voice_sample_0 <= it.voice[0];
    voice_sample_1 <= it.voice[1];
    voice_sample_2 <= it.voice[2];
    voice_sample_3 <= it.voice[3];
    voice_end_mask <= it.ends;
    do @(posedge clk); while (in_stall);
    if (it.kind == KIND_START) starts_sent++;
    else samples_sent++;
  endtask

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9, 0) < 5) begin
        post_item(sample_item($urandom_range(3, 0) != 0, pcm_value(),
                              {pcm_value(), pcm_value(), pcm_value(), pcm_value()},
                              ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 1)) : 4'b0));
      end else begin
        post_item(start_item($urandom_range(9, 0) != 0, $urandom_range(7, 0) != 0));
      end
    end
  endtask

  // Hold input low, wait for every pending result, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] music_g, logic [CFG_DATA_W-1:0] sound_g,
                                logic [CFG_DATA_W-1:0] out_rate);
    write_reg(CFG_MUSIC_GAIN, music_g);
    write_reg(CFG_SOUND_GAIN, sound_g);
    write_reg(CFG_RATE, out_rate);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin : out_side
    int wait_n;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) wait_n = HOLD_CYCLES;
      else if ((taken / 200) % 3 == 1) wait_n = 0;
      else wait_n = $urandom_range(3, 0);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : in_side
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    post_item(start_item(1'b1, 1'b1));
    post_item(sample_item(1'b1, 16'h7FFF, {4{16'h7FFF}}, 4'b1111));
    post_item(sample_item(1'b1, 16'h8000, {4{16'h8000}}, 4'b0000));
    settle();

    write_reg(CFG_SPARE_IDX, 19'h7FFFF);
    apply_settings(19'h78000, 19'h08000, 19'd48000);
    post_item(start_item(1'b0, 1'b1));
    post_item(start_item(1'b1, 1'b0));
    repeat (4) post_item(start_item(1'b1, 1'b1));
    post_item(start_item(1'b1, 1'b1));
    post_item(start_item(1'b1, 1'b0));
    post_item(sample_item(1'b1, 16'h7FFF, {4{16'h7FFF}}, 4'b0000));
    post_item(sample_item(1'b1, 16'h8000, {4{16'h8000}}, 4'b0000));
    post_item(sample_item(1'b0, 16'h7FFF, {16'hFFFD, 16'h0003, 16'hF830, 16'h03E8}, 4'b0010));
    post_item(start_item(1'b1, 1'b1));
    post_item(sample_item(1'b1, 16'h0001, {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001}, 4'b1111));
    post_item(sample_item(1'b1, 16'hFFFF, {4{16'h7FFF}}, 4'b1111));
    post_item(start_item(1'b1, 1'b1));
    settle();

    run_random(300);
    settle();

    gap_max = 0;
    apply_settings(19'h0FFFF, 19'h0FFFF, 19'h7FFFF);
    run_random(300);
    settle();

    gap_max = 3;
    apply_settings(19'h00000, 19'h00000, 19'd1);
    run_random(250);
    settle();

    apply_settings(CFG_DATA_W'($urandom_range(65535, 0)), CFG_DATA_W'($urandom_range(65535, 0)),
                   CFG_DATA_W'($urandom_range(384000, 1)));
    run_random(300);
    settle();

    gap_max = 1;
    apply_settings(19'h04000, 19'h0C000, 19'd0);
    run_random(150);
    settle();

    gap_max = 3;
    apply_settings(CFG_DATA_W'($urandom_range(65535, 0)), CFG_DATA_W'($urandom_range(65535, 0)),
                   19'd384000);
    run_random(450);
    settle();

    $display("%0d transactions (%0d starts, %0d samples) under %0d register settings",
             starts_sent + samples_sent, starts_sent, samples_sent, settings);
    $display("output held off once for %0d cycles to back up the input", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
